@@ src/i2cm_pkg.sv @@
// Package for the I2C master byte engine: command opcodes, phase codes and
// the field widths of the stream and configuration ports.
// No dependencies; imported by i2c_master_byte_engine and its testbench.
package i2cm_pkg;

	localparam int DELAY_W  = 16;
	localparam int PHASE_W  = 4;
	localparam int OPCODE_W = 3;
	localparam int BITIDX_W = 4;

	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 16;

	localparam logic [DELAY_W-1:0] HALF_PERIOD_RESET = DELAY_W'(250);

	// Number of data bits before the acknowledge pulse.
	localparam logic [BITIDX_W-1:0] DATA_BITS = BITIDX_W'(8);

	// Command opcodes.
	localparam logic [OPCODE_W-1:0] OP_START = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_ADDR  = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_WRITE = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_READ  = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_STOP  = 3'd4;

	// Phase codes of the bus sequencer.
	localparam logic [PHASE_W-1:0] PH_IDLE     = 4'd0;
	localparam logic [PHASE_W-1:0] PH_ST_A     = 4'd1;
	localparam logic [PHASE_W-1:0] PH_ST_B     = 4'd2;
	localparam logic [PHASE_W-1:0] PH_SP_A     = 4'd3;
	localparam logic [PHASE_W-1:0] PH_SP_WAIT  = 4'd4;
	localparam logic [PHASE_W-1:0] PH_SP_B     = 4'd5;
	localparam logic [PHASE_W-1:0] PH_BIT_LOW  = 4'd6;
	localparam logic [PHASE_W-1:0] PH_BIT_WAIT = 4'd7;
	localparam logic [PHASE_W-1:0] PH_BIT_HIGH = 4'd8;
	localparam logic [PHASE_W-1:0] PH_TAIL     = 4'd9;

endpackage

@@ src/i2c_master_byte_engine.sv @@
// I2C master byte engine: command sequencer, line drive and status result.
// Depends on i2cm_pkg (opcodes, phase codes, widths).

// Each input transaction on the s_axis side is one timebase tick. It carries
// an optional command (cmd_valid, opcode and its operands) together with the
// sampled SCL and SDA line levels, and it produces exactly one output
// transaction on the m_axis side holding the open-drain pull-down drives, the
// ready and done status, the NACK flag and the last received byte, all as
// they stand after that tick. The sequencer state advances by
// at most one phase per transaction, and a new transaction is taken
// in every cycle as long as the output register is empty or being
// drained in the same cycle, so the sustained rate is one tick
// per clock. Commands are only taken while the engine reports ready; they
// complete after a number of ticks set by half_period_ticks and by how long a
// slave stretches the clock. Every timed step lasts half_period_ticks + 1
// ticks. half_period_ticks is written through cfg_we/cfg_wdata and should only
// be changed while the engine is idle.
module i2c_master_byte_engine (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration: half_period_ticks.
	input  logic                              cfg_we,
	input  logic [i2cm_pkg::DELAY_W-1:0]      cfg_wdata,
	// Tick input.
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// tdata, low bit up: cmd_valid[0], slave_address[7:1], read_flag[8],
	// tx_byte[16:9], final_byte[17], scl_level[18], sda_level[19], zero fill.
	input  logic [i2cm_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	// tuser: opcode[2:0].
	input  logic [i2cm_pkg::OPCODE_W-1:0]     s_axis_tuser,
	// Result output.
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// tdata, low bit up: scl_pull_low[0], sda_pull_low[1], ready_res[2],
	// done_res[3], nack_seen[4], rx_byte[12:5], zero fill.
	output logic [i2cm_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
	import i2cm_pkg::*;

	// Unpacked input fields.
	logic                cmd_valid;
	logic [6:0]          slave_address;
	logic                read_flag;
	logic [7:0]          tx_byte;
	logic                final_byte;
	logic                scl_level;
	logic                sda_level;
	logic [OPCODE_W-1:0] opcode;

	assign cmd_valid     = s_axis_tdata[0];
	assign slave_address = s_axis_tdata[7:1];
	assign read_flag     = s_axis_tdata[8];
	assign tx_byte       = s_axis_tdata[16:9];
	assign final_byte    = s_axis_tdata[17];
	assign scl_level     = s_axis_tdata[18];
	assign sda_level     = s_axis_tdata[19];
	assign opcode        = s_axis_tuser;

	// Sequencer state.
	logic [DELAY_W-1:0]  half_q;
	logic [PHASE_W-1:0]  phase_q,   phase_d;
	logic [DELAY_W-1:0]  dcnt_q,    dcnt_d;
	logic [BITIDX_W-1:0] bidx_q,    bidx_d;
	logic [7:0]          shift_q,   shift_d;
	logic                last_q,    last_d;
	logic [OPCODE_W-1:0] pend_q,    pend_d;
	logic                nack_q,    nack_d;
	logic                astop_q,   astop_d;
	logic                scl_drv_q, scl_drv_d;
	logic                sda_drv_q, sda_drv_d;
	logic [7:0]          rx_q,      rx_d;
	logic                done_d;

	logic                out_vld_q;
	logic [OUT_TDATA_W-1:0] out_data_q;

	logic                accept;
	logic                reading;
	logic                elapsed;
	logic [DELAY_W-1:0]  dcnt_step;

	// The output register frees up in the same cycle it is drained.
	assign s_axis_tready = !out_vld_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign reading   = (pend_q == OP_READ);
	assign elapsed   = (dcnt_q >= half_q);
	// Count value for a timed phase that keeps waiting or finishes this tick.
	assign dcnt_step = elapsed ? '0 : dcnt_q + DELAY_W'(1);

	always_comb begin
		phase_d   = phase_q;
		dcnt_d    = dcnt_q;
		bidx_d    = bidx_q;
		shift_d   = shift_q;
		last_d    = last_q;
		pend_d    = pend_q;
		nack_d    = nack_q;
		astop_d   = astop_q;
		scl_drv_d = scl_drv_q;
		sda_drv_d = sda_drv_q;
		rx_d      = rx_q;
		done_d    = 1'b0;

		unique case (phase_q)
			PH_IDLE: begin
				if (cmd_valid && (opcode <= OP_STOP)) begin
					nack_d  = 1'b0;
					astop_d = 1'b0;
					pend_d  = opcode;
					bidx_d  = '0;
					dcnt_d  = '0;
					if (opcode == OP_START) begin
						phase_d = PH_ST_A;
					end else if (opcode == OP_STOP) begin
						phase_d = PH_SP_A;
					end else begin
						if (opcode == OP_ADDR) begin
							shift_d = {slave_address, read_flag};
							last_d  = 1'b0;
						end else if (opcode == OP_WRITE) begin
							shift_d = tx_byte;
							last_d  = final_byte;
						end else begin
							shift_d = '0;
							last_d  = final_byte;
						end
						phase_d = PH_BIT_LOW;
					end
				end
			end
			PH_ST_A: begin
				scl_drv_d = 1'b0;
				sda_drv_d = 1'b0;
				dcnt_d    = dcnt_step;
				if (elapsed) begin
					sda_drv_d = 1'b1;
					phase_d   = PH_ST_B;
				end
			end
			PH_ST_B: begin
				dcnt_d = dcnt_step;
				if (elapsed) begin
					scl_drv_d = 1'b1;
					phase_d   = PH_IDLE;
					done_d    = 1'b1;
				end
			end
			PH_SP_A: begin
				sda_drv_d = 1'b1;
				dcnt_d    = dcnt_step;
				if (elapsed) begin
					scl_drv_d = 1'b0;
					phase_d   = PH_SP_WAIT;
				end
			end
			PH_SP_WAIT: begin
				// Clock stretching: hold until the line really reads high.
				if (scl_level) begin
					phase_d = PH_SP_B;
					dcnt_d  = '0;
				end
			end
			PH_SP_B: begin
				dcnt_d = dcnt_step;
				if (elapsed) begin
					sda_drv_d = 1'b0;
					phase_d   = PH_IDLE;
					done_d    = 1'b1;
				end
			end
			PH_BIT_LOW: begin
				// Data bits: a read releases SDA, a write sends the MSB.
				// Acknowledge bit: a read ACKs unless final, a write releases.
				if (bidx_q < DATA_BITS) begin
					sda_drv_d = reading ? 1'b0 : !shift_q[7];
				end else begin
					sda_drv_d = reading ? !last_q : 1'b0;
				end
				dcnt_d = dcnt_step;
				if (elapsed) begin
					scl_drv_d = 1'b0;
					phase_d   = PH_BIT_WAIT;
				end
			end
			PH_BIT_WAIT: begin
				if (scl_level) begin
					phase_d = PH_BIT_HIGH;
					dcnt_d  = '0;
				end
			end
			PH_BIT_HIGH: begin
				dcnt_d = dcnt_step;
				if (elapsed) begin
					scl_drv_d = 1'b1;
					if (bidx_q < DATA_BITS) begin
						shift_d = {shift_q[6:0], reading & sda_level};
						bidx_d  = bidx_q + BITIDX_W'(1);
						phase_d = PH_BIT_LOW;
					end else begin
						// The ACK of a final write byte is ignored.
						if (!reading && sda_level && !last_q) begin
							nack_d = 1'b1;
						end
						phase_d = PH_TAIL;
					end
				end
			end
			PH_TAIL: begin
				sda_drv_d = 1'b0;
				dcnt_d    = '0;
				if (reading) begin
					rx_d = shift_q;
				end
				if (nack_q) begin
					// A refused byte ends the transfer with a STOP of its own.
					astop_d = 1'b1;
					pend_d  = OP_STOP;
					phase_d = PH_SP_A;
				end else begin
					phase_d = PH_IDLE;
					done_d  = 1'b1;
				end
			end
			default: begin
				phase_d = PH_IDLE;
				dcnt_d  = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= HALF_PERIOD_RESET;
		end else if (cfg_we) begin
			half_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			dcnt_q    <= '0;
			bidx_q    <= '0;
			shift_q   <= '0;
			last_q    <= 1'b0;
			pend_q    <= '0;
			nack_q    <= 1'b0;
			astop_q   <= 1'b0;
			scl_drv_q <= 1'b0;
			sda_drv_q <= 1'b0;
			rx_q      <= '0;
		end else if (accept) begin
			phase_q   <= phase_d;
			dcnt_q    <= dcnt_d;
			bidx_q    <= bidx_d;
			shift_q   <= shift_d;
			last_q    <= last_d;
			pend_q    <= pend_d;
			nack_q    <= nack_d;
			astop_q   <= astop_d;
			scl_drv_q <= scl_drv_d;
			sda_drv_q <= sda_drv_d;
			rx_q      <= rx_d;
		end
	end

	// Output register: one result transaction per tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (accept) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= {3'b000, rx_d, nack_d, done_d,
				(phase_d == PH_IDLE), sda_drv_d, scl_drv_d};
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;

`ifndef SYNTHESIS
	// A completing command always leaves the engine ready for the next one.
	a_done_is_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[3]) |-> m_axis_tdata[2])
		else $error("done reported while the engine is busy");

	// The delay counter is only running inside a timed phase.
	a_idle_count_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE) |-> (dcnt_q == '0))
		else $error("delay counter not cleared in idle");

	// Eight data bits and one acknowledge bit, never more.
	a_bit_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		bidx_q <= DATA_BITS)
		else $error("bit index beyond the acknowledge bit");

	// The automatic stop only follows a NACK.
	a_auto_stop_nack: assert property (@(posedge clk) disable iff (!arst_n)
		astop_q |-> nack_q)
		else $error("automatic stop without a NACK");
`endif

endmodule

@@ tb/i2c_master_byte_engine_tb.sv @@
// Self-checking testbench for the I2C master byte engine: a driver, a monitor, a
// tick-accurate model of the command sequencer and a slave that answers on the bus.
// Depends on i2cm_pkg and i2c_master_byte_engine; needs no files or arguments.
`timescale 1ns / 1ps

module i2c_master_byte_engine_tb;
	import i2cm_pkg::*;

	// Opcodes that the engine must ignore.
	localparam logic [OPCODE_W-1:0] OP_RSVD5 = 3'd5;
	localparam logic [OPCODE_W-1:0] OP_RSVD6 = 3'd6;
	localparam logic [OPCODE_W-1:0] OP_RSVD7 = 3'd7;

	localparam logic [DELAY_W-1:0] HALF_AFTER_RESET = 16'd250;
	localparam int unsigned HOLD_CYCLES = 300;     // long receiver hold-off
	localparam int unsigned SETTLE_CYCLES = 4;     // pause before a register write
	localparam int unsigned WATCHDOG_LIMIT = 3000; // cycles with no transaction
	localparam int unsigned MAX_PRINTS = 40;

	// One timebase tick as offered on the input stream.
	typedef struct {
		logic                cv;
		logic [OPCODE_W-1:0] op;
		logic [6:0]          addr;
		logic                rf;
		logic [7:0]          tx;
		logic                fin;
		logic                scl;
		logic                sda;
	} tick_t;

	// Status word, laid out exactly as the output tdata from bit 0 up.
	typedef struct packed {
		logic [7:0] rx;
		logic       nack;
		logic       done;
		logic       ready;
		logic       sda;
		logic       scl;
	} status_t;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [DELAY_W-1:0] cfg_wdata = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
	logic [OPCODE_W-1:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	i2c_master_byte_engine dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	// Ticks waiting to be driven, and the status words they must produce, in order.
	tick_t   tick_q[$];
	status_t status_q[$];

	// Idle and stall rates in percent, changed only between phases.
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	logic hold_kick = 1'b0;
	logic hold_seen = 1'b0;
	int unsigned hold_left = 0;

	// Model of the engine. It runs as the ticks are generated, so the slave
	// responder below always knows what the master is doing on the bus.
	logic [DELAY_W-1:0]  eng_half = HALF_AFTER_RESET;
	logic [PHASE_W-1:0]  eng_phase = PH_IDLE;
	logic [DELAY_W-1:0]  eng_count = '0;
	logic [BITIDX_W-1:0] eng_bit = '0;
	logic [7:0]          eng_shift = '0;
	logic                eng_last = 1'b0;
	logic [OPCODE_W-1:0] eng_op = OP_START;
	logic                eng_nack = 1'b0;
	logic                eng_auto = 1'b0;
	logic                eng_scl = 1'b0;
	logic                eng_sda = 1'b0;
	logic [7:0]          eng_rx = '0;

	// Slave behavior knobs.
	int unsigned stretch_pct = 0;   // chance that a released SCL still reads low
	int unsigned noise_pct = 0;     // chance of random line levels on a tick
	int unsigned busy_cmd_pct = 0;  // chance of a command offer while busy
	logic        slave_nack = 1'b0; // level the slave leaves on SDA for the ACK bit
	logic [7:0]  slave_data = '0;   // byte the slave returns on a read

	// Run statistics.
	int unsigned ticks_made = 0;
	int unsigned cmd_seen[5] = '{default: 0};
	int unsigned auto_stops = 0;
	int unsigned ignored_offers = 0;
	int unsigned settings_used = 1;
	int unsigned results_checked = 0;
	int unsigned errors = 0;
	int unsigned quiet_cycles = 0;

	tick_t   drv_tick;
	status_t mon_got;
	status_t mon_want;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic void enter_phase(logic [PHASE_W-1:0] p);
		eng_phase = p;
		eng_count = '0;
	endfunction

	// A timed step waits eng_half ticks and then acts on the next one.
	function automatic logic half_period_up();
		if (eng_count >= eng_half) begin
			eng_count = '0;
			return 1'b1;
		end
		eng_count = eng_count + 1'b1;
		return 1'b0;
	endfunction

	// Advances the engine model by one tick and returns the status after it.
	function automatic status_t advance_engine(tick_t t);
		status_t s;
		logic reading;
		logic done;
		done = 1'b0;
		reading = (eng_op == OP_READ);
		if (t.cv && !(eng_phase == PH_IDLE && t.op <= OP_STOP))
			ignored_offers++;
		case (eng_phase)
		PH_IDLE: begin
			if (t.cv && t.op <= OP_STOP) begin
				cmd_seen[t.op]++;
				eng_nack = 1'b0;
				eng_auto = 1'b0;
				eng_op = t.op;
				eng_bit = '0;
				if (t.op == OP_START) begin
					enter_phase(PH_ST_A);
				end else if (t.op == OP_STOP) begin
					enter_phase(PH_SP_A);
				end else begin
					if (t.op == OP_ADDR) begin
						eng_shift = {t.addr, t.rf};
						eng_last = 1'b0;
					end else if (t.op == OP_WRITE) begin
						eng_shift = t.tx;
						eng_last = t.fin;
					end else begin
						eng_shift = '0;
						eng_last = t.fin;
					end
					enter_phase(PH_BIT_LOW);
				end
			end
		end
		PH_ST_A: begin
			eng_scl = 1'b0;
			eng_sda = 1'b0;
			if (half_period_up()) begin
				eng_sda = 1'b1;
				enter_phase(PH_ST_B);
			end
		end
		PH_ST_B: begin
			if (half_period_up()) begin
				eng_scl = 1'b1;
				enter_phase(PH_IDLE);
				done = 1'b1;
			end
		end
		PH_SP_A: begin
			eng_sda = 1'b1;
			if (half_period_up()) begin
				eng_scl = 1'b0;
				enter_phase(PH_SP_WAIT);
			end
		end
		PH_SP_WAIT: begin
			if (t.scl)
				enter_phase(PH_SP_B);
		end
		PH_SP_B: begin
			if (half_period_up()) begin
				eng_sda = 1'b0;
				enter_phase(PH_IDLE);
				done = 1'b1;
			end
		end
		PH_BIT_LOW: begin
			// Data bits pull SDA low for a zero; on the ACK bit a read
			// acknowledges unless it is the final byte.
			if (eng_bit < DATA_BITS)
				eng_sda = reading ? 1'b0 : ~eng_shift[7];
			else
				eng_sda = reading ? ~eng_last : 1'b0;
			if (half_period_up()) begin
				eng_scl = 1'b0;
				enter_phase(PH_BIT_WAIT);
			end
		end
		PH_BIT_WAIT: begin
			if (t.scl)
				enter_phase(PH_BIT_HIGH);
		end
		PH_BIT_HIGH: begin
			if (half_period_up()) begin
				eng_scl = 1'b1;
				if (eng_bit < DATA_BITS) begin
					eng_shift = {eng_shift[6:0], reading ? t.sda : 1'b0};
					eng_bit = eng_bit + 1'b1;
					enter_phase(PH_BIT_LOW);
				end else begin
					if (!reading && t.sda && !eng_last)
						eng_nack = 1'b1;
					enter_phase(PH_TAIL);
				end
			end
		end
		PH_TAIL: begin
			eng_sda = 1'b0;
			if (reading)
				eng_rx = eng_shift;
			if (eng_nack) begin
				// A refused address or byte turns into a STOP of its own.
				eng_auto = 1'b1;
				eng_op = OP_STOP;
				auto_stops++;
				enter_phase(PH_SP_A);
			end else begin
				enter_phase(PH_IDLE);
				done = 1'b1;
			end
		end
		default: enter_phase(PH_IDLE);
		endcase
		s.scl = eng_scl;
		s.sda = eng_sda;
		s.ready = (eng_phase == PH_IDLE);
		s.done = done;
		s.nack = eng_nack;
		s.rx = eng_rx;
		return s;
	endfunction

	// Slave and pull-up side of the bus: picks the line levels the engine samples
	// on the next tick from what it drives now.
	function automatic tick_t with_lines(tick_t t);
		logic in_bit;
		in_bit = (eng_phase == PH_BIT_LOW || eng_phase == PH_BIT_WAIT
			|| eng_phase == PH_BIT_HIGH);
		if (eng_scl)
			t.scl = 1'b0;
		else
			t.scl = ($urandom_range(0, 99) >= stretch_pct);
		if (eng_sda)
			t.sda = 1'b0;
		else if (in_bit && eng_bit == DATA_BITS && eng_op != OP_READ)
			t.sda = slave_nack;
		else if (in_bit && eng_bit < DATA_BITS && eng_op == OP_READ)
			t.sda = slave_data[3'd7 - eng_bit[2:0]];
		else
			t.sda = 1'b1;
		if ($urandom_range(0, 99) < noise_pct) begin
			t.scl = 1'($urandom);
			t.sda = 1'($urandom);
		end
		return t;
	endfunction

	// A tick with no command and random content in the operand fields.
	function automatic tick_t idle_tick();
		tick_t t;
		t.cv = 1'b0;
		t.op = 3'($urandom);
		t.addr = 7'($urandom);
		t.rf = 1'($urandom);
		t.tx = 8'($urandom);
		t.fin = 1'($urandom);
		t.scl = 1'b0;
		t.sda = 1'b0;
		return t;
	endfunction

	task automatic put_tick(tick_t t);
		tick_t lt;
		lt = with_lines(t);
		status_q.push_back(advance_engine(lt));
		tick_q.push_back(lt);
		ticks_made++;
	endtask

	task automatic gap(int unsigned n);
		repeat (n) put_tick(idle_tick());
	endtask

	// Offers a command to the idle engine and keeps ticking until it is idle again.
	task automatic issue(logic [OPCODE_W-1:0] op, logic [6:0] addr, logic rf,
			logic [7:0] tx, logic fin);
		tick_t t;
		t = idle_tick();
		t.cv = 1'b1;
		t.op = op;
		t.addr = addr;
		t.rf = rf;
		t.tx = tx;
		t.fin = fin;
		put_tick(t);
		while (eng_phase != PH_IDLE) begin
			t = idle_tick();
			if ($urandom_range(0, 99) < busy_cmd_pct)
				t.cv = 1'b1;
			put_tick(t);
		end
	endtask

	// START, address, one to three bytes in the addressed direction, STOP.
	// A NACK ends the transfer early, since the engine stops by itself.
	task automatic random_transfer();
		logic rf;
		int unsigned nbytes;
		rf = 1'($urandom);
		nbytes = $urandom_range(1, 3);
		issue(OP_START, 7'($urandom), 1'($urandom), 8'($urandom), 1'($urandom));
		gap($urandom_range(0, 3));
		slave_nack = ($urandom_range(0, 5) == 0);
		issue(OP_ADDR, 7'($urandom), rf, 8'($urandom), 1'($urandom));
		for (int unsigned i = 0; i < nbytes && !eng_nack; i++) begin
			gap($urandom_range(0, 3));
			slave_nack = ($urandom_range(0, 5) == 0);
			slave_data = 8'($urandom);
			issue(rf ? OP_READ : OP_WRITE, 7'($urandom), 1'($urandom), 8'($urandom),
				i == nbytes - 1);
		end
		if (!eng_nack) begin
			gap($urandom_range(0, 3));
			issue(OP_STOP, 7'($urandom), 1'($urandom), 8'($urandom), 1'($urandom));
		end
	endtask

	// Mostly well-formed transfers, the rest single commands of any opcode.
	task automatic random_phase(int unsigned count);
		int unsigned stop_at;
		stop_at = ticks_made + count;
		stretch_pct = 20;
		noise_pct = 3;
		busy_cmd_pct = 5;
		while (ticks_made < stop_at) begin
			if ($urandom_range(0, 4) != 0) begin
				random_transfer();
			end else begin
				slave_nack = 1'($urandom);
				slave_data = 8'($urandom);
				issue(3'($urandom_range(0, 7)), 7'($urandom), 1'($urandom),
					8'($urandom), 1'($urandom));
				gap($urandom_range(0, 4));
			end
		end
	endtask

	task automatic wait_drained();
		while (tick_q.size() != 0 || status_q.size() != 0)
			@(posedge clk);
	endtask

	// Waits for the engine to go idle, then writes half_period_ticks and sets
	// the idle and stall rates of the next phase.
	task automatic start_phase(logic [DELAY_W-1:0] half, int unsigned send_pct,
			int unsigned recv_pct);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= half;
		send_idle_pct <= send_pct;
		recv_stall_pct <= recv_pct;
		@(posedge clk);
		cfg_we <= 1'b0;
		eng_half = half;
		settings_used++;
	endtask

	task automatic flag_mismatch(string what, logic [7:0] got, logic [7:0] want);
		if (errors < MAX_PRINTS)
			$display("MISMATCH at result %0d, %s: got %h, expected %h",
				results_checked, what, got, want);
		errors++;
	endtask

	// Driver: a new tick goes out when the line is empty or the current
	// transaction completes at this edge, unless the sender idles.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (tick_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				drv_tick = tick_q.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= {4'b0, drv_tick.sda, drv_tick.scl, drv_tick.fin, drv_tick.tx,
					drv_tick.rf, drv_tick.addr, drv_tick.cv};
				s_axis_tuser <= drv_tick.op;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, plus a long hold-off whenever the main sequence
	// toggles hold_kick. The sender keeps offering ticks meanwhile, so the
	// engine fills up and has to push back on its input.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (hold_left != 0) begin
			m_axis_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_kick != hold_seen) begin
			hold_seen <= hold_kick;
			hold_left <= HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Monitor: every status transaction is checked field by field against the
	// oldest prediction.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			mon_got = m_axis_tdata[12:0];
			if (status_q.size() == 0) begin
				flag_mismatch("result with none expected", mon_got[7:0], 8'h00);
			end else begin
				mon_want = status_q.pop_front();
				if (mon_got.scl !== mon_want.scl)
					flag_mismatch("scl_pull_low", 8'(mon_got.scl), 8'(mon_want.scl));
				if (mon_got.sda !== mon_want.sda)
					flag_mismatch("sda_pull_low", 8'(mon_got.sda), 8'(mon_want.sda));
				if (mon_got.ready !== mon_want.ready)
					flag_mismatch("ready_res", 8'(mon_got.ready), 8'(mon_want.ready));
				if (mon_got.done !== mon_want.done)
					flag_mismatch("done_res", 8'(mon_got.done), 8'(mon_want.done));
				if (mon_got.nack !== mon_want.nack)
					flag_mismatch("nack_seen", 8'(mon_got.nack), 8'(mon_want.nack));
				if (mon_got.rx !== mon_want.rx)
					flag_mismatch("rx_byte", mon_got.rx, mon_want.rx);
			end
			results_checked++;
		end
	end

	// Watchdog: ends the run if neither side moves a transaction for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready)
				|| (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog: no transaction for %0d cycles", quiet_cycles);
			$display("Test completed with failures");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// The register still holds its reset value: one START shows the
		// 250-tick half period.
		issue(OP_START, '0, 1'b0, '0, 1'b0);

		// Directed part with zero delay, so that every timed step is one tick.
		start_phase(16'd0, 0, 0);
		issue(OP_START, '0, 1'b0, '0, 1'b0);
		slave_nack = 1'b0;
		issue(OP_ADDR, 7'h7F, 1'b0, 8'hFF, 1'b1);
		issue(OP_WRITE, 7'h00, 1'b0, 8'hFF, 1'b0);
		// A final write byte ignores the slave's NACK.
		slave_nack = 1'b1;
		issue(OP_WRITE, 7'h7F, 1'b1, 8'h00, 1'b1);
		slave_nack = 1'b0;
		issue(OP_ADDR, 7'h00, 1'b1, 8'h00, 1'b0);
		slave_data = 8'hA5;
		issue(OP_READ, 7'h00, 1'b0, 8'h00, 1'b0);
		slave_data = 8'h5A;
		issue(OP_READ, 7'h7F, 1'b1, 8'hFF, 1'b1);
		issue(OP_STOP, '0, 1'b0, '0, 1'b0);
		// Unused opcodes leave the engine idle.
		issue(OP_RSVD5, '0, 1'b0, '0, 1'b0);
		issue(OP_RSVD6, 7'h2A, 1'b0, 8'h55, 1'b0);
		issue(OP_RSVD7, 7'h7F, 1'b1, 8'hFF, 1'b1);
		// The address ACK counts even when final_byte is set.
		issue(OP_START, '0, 1'b0, '0, 1'b0);
		slave_nack = 1'b1;
		issue(OP_ADDR, 7'h55, 1'b0, 8'h00, 1'b1);
		// A refused non-final write byte triggers the automatic STOP.
		issue(OP_START, '0, 1'b0, '0, 1'b0);
		slave_nack = 1'b0;
		issue(OP_ADDR, 7'h2A, 1'b0, 8'h00, 1'b0);
		slave_nack = 1'b1;
		issue(OP_WRITE, 7'h00, 1'b0, 8'h3C, 1'b0);
		// Heavy clock stretching on the STOP and commands offered while busy.
		stretch_pct = 90;
		busy_cmd_pct = 50;
		slave_nack = 1'b0;
		issue(OP_START, '0, 1'b0, '0, 1'b0);
		issue(OP_STOP, '0, 1'b0, '0, 1'b0);

		// Random part, one phase per idling pattern and two delays.
		start_phase(16'd1, 0, 0);
		random_phase(20);
		start_phase(16'd0, 74, 0);
		random_phase(20);
		start_phase(16'd0, 0, 74);
		hold_kick <= ~hold_kick;
		random_phase(20);
		start_phase(16'd0, 23, 23);
		random_phase(10);
		// The sender waits here until every status word is back.
		wait_drained();
		random_phase(10);

		wait_drained();
		repeat (8) @(posedge clk);

		$display("Ran %0d ticks under %0d half-period settings; %0d status words checked.",
			ticks_made, settings_used, results_checked);
		$display("Commands: %0d start, %0d address, %0d write, %0d read, %0d stop;",
			cmd_seen[OP_START], cmd_seen[OP_ADDR], cmd_seen[OP_WRITE], cmd_seen[OP_READ],
			cmd_seen[OP_STOP]);
		$display("%0d auto stops, %0d offers ignored.", auto_stops, ignored_offers);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
